// ----- rtl/star_cif_byte_tokenizer_core_assert.svh -----
// assertion macros included by the tokenizer top level
// depends on nothing; included inside module bodies
`ifndef STAR_CIF_BYTE_TOKENIZER_CORE_ASSERT_SVH
`define STAR_CIF_BYTE_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// next-cycle implication, checked outside reset
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ----- rtl/sct_pkg.sv -----
// types, constants and reset values for the star/cif byte tokenizer
// no dependencies; imported by every tokenizer module
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    localparam int LINE_BITS     = 24;
    localparam int MAX_RESULTS   = 3;
    localparam int RES_CNT_BITS  = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_BARE    = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_TEXT    = 3'd4,
        MODE_HALTED  = 3'd5
    } t_lex_mode;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    localparam logic ERR_QUOTE = 1'b0;
    localparam logic ERR_TEXT  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           token_byte;
        logic                 token_start;
        logic                 token_quoted;
        logic [LINE_BITS-1:0] start_line;
        logic                 error_code;
        logic                 last_of_run;
    } t_out_item;

    typedef struct packed {
        t_lex_mode            mode;
        logic                 quote_is_double;
        logic                 held_quote;
        logic                 held_newline;
        logic                 held_carriage_return;
        logic                 at_line_start;
        logic [LINE_BITS-1:0] line_counter;
        logic [LINE_BITS-1:0] token_line;
        logic                 start_pending;
        logic                 cur_quoted;
    } t_lex_state;

    // lexer state plus the results gathered during one item
    typedef struct packed {
        t_lex_state                     st;
        logic [RES_CNT_BITS-1:0]        cnt;
        t_out_item [MAX_RESULTS-1:0]    res;
    } t_step;

    localparam t_lex_state STATE_RESET = '{
        mode:                 MODE_BETWEEN,
        quote_is_double:      1'b0,
        held_quote:           1'b0,
        held_newline:         1'b0,
        held_carriage_return: 1'b0,
        at_line_start:        1'b1,
        line_counter:         LINE_BITS'(1),
        token_line:           '0,
        start_pending:        1'b0,
        cur_quoted:           1'b0
    };

endpackage

`default_nettype wire

// ----- rtl/sct_lex_step.sv -----
// combinational lexer step: next lexer state and up to three results per item
// depends on sct_pkg
`timescale 1ns / 1ps
`default_nettype none

module sct_lex_step (
    input  wire sct_pkg::t_lex_state                           i_state,
    input  wire sct_pkg::t_in_item                             i_item,
    output sct_pkg::t_lex_state                                o_next_state,
    output logic [sct_pkg::RES_CNT_BITS-1:0]                   o_res_cnt,
    output sct_pkg::t_out_item [sct_pkg::MAX_RESULTS-1:0]      o_res
);
    import sct_pkg::*;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // append one result, stamped with the current token attributes
    function automatic t_step emit(t_step s, t_kind k, logic [7:0] b, logic err);
        t_step     r;
        t_out_item o;
        r              = s;
        o.kind         = k;
        o.token_byte   = (k == KIND_BYTE) ? b : 8'd0;
        o.token_start  = (k != KIND_ERROR) && s.st.start_pending;
        o.token_quoted = (k == KIND_ERROR) ? 1'b1 : s.st.cur_quoted;
        o.start_line   = s.st.token_line;
        o.error_code   = (k == KIND_ERROR) ? err : 1'b0;
        o.last_of_run  = 1'b0;
        if (s.cnt < RES_CNT_BITS'(MAX_RESULTS)) begin
            r.res[s.cnt]        = o;
            r.cnt               = s.cnt + RES_CNT_BITS'(1);
            r.st.start_pending  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_step open_token(t_step s, logic quoted);
        t_step r;
        r                  = s;
        r.st.token_line    = s.st.line_counter;
        r.st.start_pending = 1'b1;
        r.st.cur_quoted    = quoted;
        return r;
    endfunction

    // one ordinary character (a dropped-cr pair never reaches here)
    function automatic t_step char_in(t_step s, logic [7:0] c);
        t_step      r;
        logic       ws;
        logic [7:0] q;
        logic       done;
        r    = s;
        ws   = is_blank(c);
        q    = s.st.quote_is_double ? CH_DQUOT : CH_SQUOT;
        done = 1'b0;
        unique case (r.st.mode)
            MODE_BETWEEN: begin
                if (ws) begin
                    done = 1'b1;
                end else if (r.st.at_line_start && (c == CH_SEMI)) begin
                    r.st.mode         = MODE_TEXT;
                    r.st.held_newline = 1'b0;
                    r                 = open_token(r, 1'b1);
                end else if (c == CH_HASH) begin
                    r.st.mode = MODE_COMMENT;
                end else if ((c == CH_SQUOT) || (c == CH_DQUOT)) begin
                    r.st.mode            = MODE_QUOTED;
                    r.st.quote_is_double = (c == CH_DQUOT);
                    r.st.held_quote      = 1'b0;
                    r                    = open_token(r, 1'b1);
                end else begin
                    r.st.mode = MODE_BARE;
                    r         = open_token(r, 1'b0);
                    r         = emit(r, KIND_BYTE, c, 1'b0);
                end
            end
            MODE_BARE: begin
                if (ws) begin
                    r         = emit(r, KIND_END, 8'd0, 1'b0);
                    r.st.mode = MODE_BETWEEN;
                end else begin
                    r = emit(r, KIND_BYTE, c, 1'b0);
                end
            end
            MODE_QUOTED: begin
                // a held quote closes only before whitespace
                if (r.st.held_quote) begin
                    r.st.held_quote = 1'b0;
                    if (ws) begin
                        r         = emit(r, KIND_END, 8'd0, 1'b0);
                        r.st.mode = MODE_BETWEEN;
                        done      = 1'b1;
                    end else begin
                        r = emit(r, KIND_BYTE, q, 1'b0);
                    end
                end
                if (!done) begin
                    if (c == q) begin
                        r.st.held_quote = 1'b1;
                    end else begin
                        r = emit(r, KIND_BYTE, c, 1'b0);
                    end
                end
            end
            MODE_TEXT: begin
                // a held newline followed by ';' closes the text field
                if (r.st.held_newline) begin
                    r.st.held_newline = 1'b0;
                    if (c == CH_SEMI) begin
                        r         = emit(r, KIND_END, 8'd0, 1'b0);
                        r.st.mode = MODE_BETWEEN;
                        done      = 1'b1;
                    end else begin
                        r = emit(r, KIND_BYTE, CH_LF, 1'b0);
                    end
                end
                if (!done) begin
                    r = emit(r, KIND_BYTE, c, 1'b0);
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
        r.st.at_line_start = 1'b0;
        return r;
    endfunction

    function automatic t_step line_end(t_step s);
        t_step r;
        logic  halt;
        r    = s;
        halt = 1'b0;
        unique case (r.st.mode)
            MODE_BARE: begin
                r         = emit(r, KIND_END, 8'd0, 1'b0);
                r.st.mode = MODE_BETWEEN;
            end
            MODE_QUOTED: begin
                if (r.st.held_quote) begin
                    r.st.held_quote = 1'b0;
                    r               = emit(r, KIND_END, 8'd0, 1'b0);
                    r.st.mode       = MODE_BETWEEN;
                end else begin
                    r         = emit(r, KIND_ERROR, 8'd0, ERR_QUOTE);
                    r.st.mode = MODE_HALTED;
                    halt      = 1'b1;
                end
            end
            MODE_COMMENT: begin
                r.st.mode = MODE_BETWEEN;
            end
            MODE_TEXT: begin
                if (r.st.held_newline) begin
                    r = emit(r, KIND_BYTE, CH_LF, 1'b0);
                end
                r.st.held_newline = 1'b1;
            end
            default: begin
                halt = 1'b0;
            end
        endcase
        if (!halt) begin
            if (r.st.line_counter != LINE_MAX) begin
                r.st.line_counter = r.st.line_counter + LINE_BITS'(1);
            end
            r.st.at_line_start = 1'b1;
        end
        return r;
    endfunction

    // full step for one accepted item
    function automatic t_step step(t_lex_state s, t_in_item it);
        t_step r;
        logic  nonempty;
        r.st     = s;
        r.cnt    = '0;
        r.res    = '0;
        nonempty = 1'b0;
        if (s.mode != MODE_HALTED) begin
            if (it.end_of_stream) begin
                nonempty                  = !s.at_line_start || s.held_carriage_return;
                r.st.held_carriage_return = 1'b0;
                if (nonempty) begin
                    r = line_end(r);
                end
                if (r.st.mode == MODE_TEXT) begin
                    r = emit(r, KIND_ERROR, 8'd0, ERR_TEXT);
                end
                r.st.mode = MODE_HALTED;
            end else if (it.in_byte == CH_CR) begin
                if (s.held_carriage_return) begin
                    r = char_in(r, CH_CR);
                end
                r.st.held_carriage_return = 1'b1;
            end else if (it.in_byte == CH_LF) begin
                r.st.held_carriage_return = 1'b0;
                r                         = line_end(r);
            end else begin
                if (s.held_carriage_return) begin
                    r.st.held_carriage_return = 1'b0;
                    r                         = char_in(r, CH_CR);
                end
                r = char_in(r, it.in_byte);
            end
            if (r.cnt != '0) begin
                r.res[r.cnt - RES_CNT_BITS'(1)].last_of_run = 1'b1;
            end
        end
        return r;
    endfunction

    t_step w_step;

    // next lexer state and results of this item
    always_comb begin
        w_step       = step(i_state, i_item);
        o_next_state = w_step.st;
        o_res_cnt    = w_step.cnt;
        o_res        = w_step.res;
    end

endmodule

`default_nettype wire

// ----- rtl/sct_res_fifo.sv -----
// small result queue: takes up to three results a cycle, hands out one
// depends on sct_pkg
`timescale 1ns / 1ps
`default_nettype none

module sct_res_fifo (
    input  wire                                                i_clk,
    input  wire                                                i_rst_n,
    input  wire  [sct_pkg::RES_CNT_BITS-1:0]                   i_push_cnt,
    input  wire  sct_pkg::t_out_item [sct_pkg::MAX_RESULTS-1:0] i_push_items,
    input  wire                                                i_pop,
    output logic                                               o_room,
    output logic                                               o_valid,
    output sct_pkg::t_out_item                                 o_head
);
    import sct_pkg::*;

    t_out_item                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] n_count;

    // storage writes, up to three consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_CNT_BITS'(k) < i_push_cnt) begin
                r_mem[r_wr_ptr + FIFO_PTR_BITS'(k)] <= i_push_items[k];
            end
        end
    end

    // occupancy after this cycle's push and pop
    always_comb begin
        n_count = r_count + FIFO_CNT_BITS'(i_push_cnt) - FIFO_CNT_BITS'(i_pop);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(i_pop);
            r_count  <= n_count;
        end
    end

    // room for a worst-case item, head of queue
    assign o_room  = (r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/star_cif_byte_tokenizer_core.sv -----
// star/cif 1.1 byte tokenizer top level: lexer state register and result queue
// depends on sct_pkg, sct_lex_step, sct_res_fifo, star_cif_byte_tokenizer_core_assert.svh
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_item) takes one byte of the
//   file, or an end-of-stream marker, per accepted item
//   output channel (o_out_valid / i_out_ready / o_out_item) returns zero to
//   three results per item: content bytes, token ends and errors, the last
//   result of an item flagged by last_of_run
//   results of an item are registered in the result queue and offered from its head
//   throughput: one item per cycle while each item yields at most one result
//   and the receiver keeps up; an item yielding more results is absorbed by a
//   four-entry result queue, and input ready drops while fewer than three
//   queue entries are free
//   receiver stall: results wait in the queue, input ready falls once the
//   queue cannot take a worst-case item; nothing is lost
//   reset: synchronous, active low; lexer returns to between tokens at line 1
//   and the queue empties
//   after an error or end of stream the lexer halts: items are still accepted
//   but give no results until reset
`timescale 1ns / 1ps
`default_nettype none

module star_cif_byte_tokenizer_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire sct_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output sct_pkg::t_out_item  o_out_item
);
    import sct_pkg::*;

    t_lex_state                     r_state;
    t_lex_state                     w_next_state;
    logic [RES_CNT_BITS-1:0]        w_res_cnt;
    t_out_item [MAX_RESULTS-1:0]    w_res;
    logic [RES_CNT_BITS-1:0]        w_push_cnt;
    logic                           w_in_acc;
    logic                           w_room;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = w_room;
    assign w_push_cnt = w_in_acc ? w_res_cnt : '0;

    // lexer step logic
    sct_lex_step u_step (
        .i_state      (r_state),
        .i_item       (i_in_item),
        .o_next_state (w_next_state),
        .o_res_cnt    (w_res_cnt),
        .o_res        (w_res)
    );

    // lexer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_in_acc) begin
            r_state <= w_next_state;
        end
    end

    // result queue
    sct_res_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (w_push_cnt),
        .i_push_items (w_res),
        .i_pop        (o_out_valid && i_out_ready),
        .o_room       (w_room),
        .o_valid      (o_out_valid),
        .o_head       (o_out_item)
    );

    `include "star_cif_byte_tokenizer_core_assert.svh"

    `SCT_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_state.mode == MODE_HALTED, r_state.mode == MODE_HALTED)
    `SCT_ASSERT_NOW(a_halt_silent, i_clk, i_rst_n, r_state.mode == MODE_HALTED, w_res_cnt == '0)
    `SCT_ASSERT_NOW(a_nl_in_text, i_clk, i_rst_n, r_state.held_newline, (r_state.mode == MODE_TEXT) || (r_state.mode == MODE_HALTED))
    `SCT_ASSERT_NOW(a_quote_held, i_clk, i_rst_n, r_state.held_quote, r_state.mode == MODE_QUOTED)
    `SCT_ASSERT_NOW(a_line_nonzero, i_clk, i_rst_n, 1'b1, r_state.line_counter != '0)

endmodule

`default_nettype wire

// ----- sim/tb_star_cif_byte_tokenizer_core.sv -----
// testbench for star_cif_byte_tokenizer_core: directed and random byte streams,
// checked result by result against a behavioral tokenizer kept in this file
// depends on sct_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb_star_cif_byte_tokenizer_core;

    import sct_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // expected tokenizer results, oldest first
    t_out_item  awaited_results[$];
    t_out_item  step_results[$];
    logic [7:0] frag_bytes[$];

    // behavioral lexer state
    t_lex_state lx;

    int  fails;
    int  items_sent;
    int  results_checked;
    bit  no_idle_in;
    bit  no_idle_out;

    star_cif_byte_tokenizer_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("tb_star_cif_byte_tokenizer_core: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- lexer model

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic void emit_result(input t_kind k, input logic [7:0] b, input logic err);
        t_out_item r;
        if (step_results.size() >= MAX_RESULTS) return;
        r              = '0;
        r.kind         = k;
        r.token_byte   = (k == KIND_BYTE) ? b : 8'd0;
        r.token_start  = (k != KIND_ERROR) && lx.start_pending;
        r.token_quoted = (k == KIND_ERROR) ? 1'b1 : lx.cur_quoted;
        r.start_line   = lx.token_line;
        r.error_code   = (k == KIND_ERROR) ? err : 1'b0;
        r.last_of_run  = 1'b0;
        lx.start_pending = 1'b0;
        step_results = {step_results, r};
    endfunction

    function automatic void open_token(input logic quoted);
        lx.token_line    = lx.line_counter;
        lx.start_pending = 1'b1;
        lx.cur_quoted    = quoted;
    endfunction

    // one ordinary character
    function automatic void lex_char(input logic [7:0] c);
        bit         ws;
        bit         done;
        logic [7:0] q;
        ws   = is_blank(c);
        done = 1'b0;
        case (lx.mode)
            MODE_BETWEEN: begin
                if (ws) begin
                end else if (lx.at_line_start && c == CH_SEMI) begin
                    lx.mode         = MODE_TEXT;
                    lx.held_newline = 1'b0;
                    open_token(1'b1);
                end else if (c == CH_HASH) begin
                    lx.mode = MODE_COMMENT;
                end else if (c == CH_SQUOT || c == CH_DQUOT) begin
                    lx.mode            = MODE_QUOTED;
                    lx.quote_is_double = (c == CH_DQUOT);
                    lx.held_quote      = 1'b0;
                    open_token(1'b1);
                end else begin
                    lx.mode = MODE_BARE;
                    open_token(1'b0);
                    emit_result(KIND_BYTE, c, 1'b0);
                end
            end
            MODE_BARE: begin
                if (ws) begin
                    emit_result(KIND_END, 8'd0, 1'b0);
                    lx.mode = MODE_BETWEEN;
                end else begin
                    emit_result(KIND_BYTE, c, 1'b0);
                end
            end
            MODE_QUOTED: begin
                q = lx.quote_is_double ? CH_DQUOT : CH_SQUOT;
                // a held quote closes only before whitespace
                if (lx.held_quote) begin
                    lx.held_quote = 1'b0;
                    if (ws) begin
                        emit_result(KIND_END, 8'd0, 1'b0);
                        lx.mode = MODE_BETWEEN;
                        done    = 1'b1;
                    end else begin
                        emit_result(KIND_BYTE, q, 1'b0);
                    end
                end
                if (!done) begin
                    if (c == q) lx.held_quote = 1'b1;
                    else emit_result(KIND_BYTE, c, 1'b0);
                end
            end
            MODE_TEXT: begin
                // a held newline is dropped only before the closing semicolon
                if (lx.held_newline) begin
                    lx.held_newline = 1'b0;
                    if (c == CH_SEMI) begin
                        emit_result(KIND_END, 8'd0, 1'b0);
                        lx.mode = MODE_BETWEEN;
                        done    = 1'b1;
                    end else begin
                        emit_result(KIND_BYTE, CH_LF, 1'b0);
                    end
                end
                if (!done) emit_result(KIND_BYTE, c, 1'b0);
            end
            default: begin
            end
        endcase
        lx.at_line_start = 1'b0;
    endfunction

    function automatic void lex_line_end();
        case (lx.mode)
            MODE_BARE: begin
                emit_result(KIND_END, 8'd0, 1'b0);
                lx.mode = MODE_BETWEEN;
            end
            MODE_QUOTED: begin
                if (lx.held_quote) begin
                    lx.held_quote = 1'b0;
                    emit_result(KIND_END, 8'd0, 1'b0);
                    lx.mode = MODE_BETWEEN;
                end else begin
                    emit_result(KIND_ERROR, 8'd0, ERR_QUOTE);
                    lx.mode = MODE_HALTED;
                    return;
                end
            end
            MODE_COMMENT: lx.mode = MODE_BETWEEN;
            MODE_TEXT: begin
                if (lx.held_newline) emit_result(KIND_BYTE, CH_LF, 1'b0);
                lx.held_newline = 1'b1;
            end
            default: begin
            end
        endcase
        if (lx.line_counter < LINE_MAX) lx.line_counter = lx.line_counter + 1'b1;
        lx.at_line_start = 1'b1;
    endfunction

    // expected results of one accepted item
    function automatic void predict_item(input t_in_item item);
        bit nonempty;
        if (lx.mode == MODE_HALTED) return;
        step_results.delete();
        if (item.end_of_stream) begin
            nonempty = !lx.at_line_start || lx.held_carriage_return;
            lx.held_carriage_return = 1'b0;
            if (nonempty) lex_line_end();
            if (lx.mode == MODE_TEXT) emit_result(KIND_ERROR, 8'd0, ERR_TEXT);
            lx.mode = MODE_HALTED;
        end else if (item.in_byte == CH_CR) begin
            if (lx.held_carriage_return) lex_char(CH_CR);
            lx.held_carriage_return = 1'b1;
        end else if (item.in_byte == CH_LF) begin
            lx.held_carriage_return = 1'b0;
            lex_line_end();
        end else begin
            if (lx.held_carriage_return) begin
                lx.held_carriage_return = 1'b0;
                lex_char(CH_CR);
            end
            lex_char(item.in_byte);
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        awaited_results = {awaited_results, step_results};
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fails++;
        end
    endfunction

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d byte %0h", out_item.kind,
                       out_item.token_byte);
                fails++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                check_field("kind",         want.kind,         out_item.kind);
                check_field("token_byte",   want.token_byte,   out_item.token_byte);
                check_field("token_start",  want.token_start,  out_item.token_start);
                check_field("token_quoted", want.token_quoted, out_item.token_quoted);
                check_field("start_line",   want.start_line,   out_item.start_line);
                check_field("error_code",   want.error_code,   out_item.error_code);
                check_field("last_of_run",  want.last_of_run,  out_item.last_of_run);
            end
        end
    end

    // receiver: random stall before each result, none while no_idle_out is set
    initial begin
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = no_idle_out ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // entered and left just after a falling edge
    task automatic send_item(input t_in_item item);
        int gap;
        gap = no_idle_in ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(item);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item item;
        item.in_byte       = b;
        item.end_of_stream = 1'b0;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_end_of_stream();
        t_in_item item;
        item.in_byte       = 8'($urandom_range(0, 255));
        item.end_of_stream = 1'b1;
        send_item(item);
    endtask

    function automatic logic [7:0] pick_word_char();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 7))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            4, 5: return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    // anything but a line feed, biased to printable text
    function automatic logic [7:0] pick_text_char();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = CH_CR;
            1: v = CH_TAB;
            2: v = 8'($urandom_range(0, 255));
            default: v = 8'($urandom_range(32, 126));
        endcase
        return (v == CH_LF) ? CH_SPACE : v;
    endfunction

    // append one byte to the fragment being built
    function automatic void add_frag(input logic [7:0] b);
        frag_bytes = {frag_bytes, b};
    endfunction

    // one well-formed piece of a cif file, or a bit of noise
    task automatic build_fragment();
        int         n;
        logic [7:0] q;
        frag_bytes.delete();
        case ($urandom_range(0, 9))
            0, 1: begin
                n = $urandom_range(1, 6);
                repeat (n) add_frag(pick_word_char());
                add_frag(pick_separator());
            end
            2, 3: begin
                q = $urandom_range(0, 1) ? CH_DQUOT : CH_SQUOT;
                add_frag(q);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    // embedded quote followed by a non-blank character, which does not close it
                    if ($urandom_range(0, 4) == 0) begin
                        add_frag(q);
                        add_frag(pick_word_char());
                    end else begin
                        add_frag(8'($urandom_range(32, 126)));
                    end
                end
                add_frag(q);
                add_frag(pick_separator());
            end
            4, 5: begin
                if (!lx.at_line_start) add_frag(CH_LF);
                add_frag(CH_SEMI);
                repeat ($urandom_range(1, 3)) begin
                    n = $urandom_range(0, 5);
                    repeat (n) add_frag(pick_text_char());
                    if ($urandom_range(0, 2) == 0) add_frag(CH_CR);
                    add_frag(CH_LF);
                end
                add_frag(CH_SEMI);
                add_frag(pick_separator());
            end
            6: begin
                add_frag(CH_HASH);
                n = $urandom_range(0, 5);
                repeat (n) add_frag(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 1)) add_frag(CH_CR);
                add_frag(CH_LF);
            end
            7, 8: begin
                n = $urandom_range(1, 3);
                repeat (n) add_frag(pick_separator());
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) add_frag(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // close whatever is open and stop at the start of a fresh line, no cr pending, or once halted
    task automatic settle_to_line_start();
        while (lx.mode != MODE_HALTED &&
               !(lx.mode == MODE_BETWEEN && lx.at_line_start && !lx.held_carriage_return)) begin
            if (lx.mode == MODE_QUOTED)
                send_byte(lx.held_quote ? CH_SPACE :
                          (lx.quote_is_double ? CH_DQUOT : CH_SQUOT));
            else if (lx.mode == MODE_TEXT && lx.held_newline)
                send_byte(CH_SEMI);
            else
                send_byte(CH_LF);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_bare_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_SPACE);
    endtask

    // embedded quote, then an empty string closed by line end
    task automatic test_quoted_strings();
        send_text("'a'b' ");
        send_text("\"\"\n");
    endtask

    // held newline released together with a lone cr and a byte
    task automatic test_text_field();
        send_text(";x\n");
        send_byte(CH_CR);
        send_text("y\n;");
    endtask

    // comment ended by crlf, then lone carriage returns before a word
    task automatic test_comment_and_cr();
        send_text("#z");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_text("a\n");
    endtask

    task automatic test_random_stream(input int count, input bit burst);
        int         stop;
        logic [7:0] b;
        no_idle_in  = burst;
        no_idle_out = burst;
        stop        = items_sent + count;
        while (items_sent < stop) begin
            build_fragment();
            foreach (frag_bytes[i]) begin
                b = frag_bytes[i];
                // a line end inside an open quote would halt the lexer for good
                if (b == CH_LF && lx.mode == MODE_QUOTED && !lx.held_quote)
                    b = pick_word_char();
                send_byte(b);
            end
        end
        no_idle_in  = 1'b0;
        no_idle_out = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        send_text("word 'str' ");
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        @(negedge clk);
        send_text("more\n");
    endtask

    // end of stream inside a text field: this error closes the run and the lexer halts
    task automatic test_end_in_text_field();
        settle_to_line_start();
        send_text(";e");
        send_byte(CH_CR);
        send_end_of_stream();
        // halted: nothing more comes out
        send_text("\n'");
        send_end_of_stream();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int waited;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        fails       = 0;
        items_sent  = 0;
        results_checked = 0;
        no_idle_in  = 1'b0;
        no_idle_out = 1'b0;
        lx          = STATE_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_bare_extremes();
        test_quoted_strings();
        test_text_field();
        test_comment_and_cr();
        test_random_stream(100, 1'b0);
        test_random_stream(40, 1'b1);
        test_pause_until_drained();
        test_random_stream(80, 1'b0);
        test_end_in_text_field();
        in_valid <= 1'b0;

        // drain, then keep watching for stray results
        waited = 0;
        while (awaited_results.size() != 0 && waited < 4000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (awaited_results.size() != 0) begin
            $error("%0d expected results never arrived", awaited_results.size());
            fails++;
        end

        $display("sent %0d items and checked %0d results: bare words, quoted strings,",
                 items_sent, results_checked);
        $display("text fields, comments, cr/lf handling, end of stream inside a text field");
        if (fails == 0) begin
            $display("tb_star_cif_byte_tokenizer_core: PASS");
        end else begin
            $display("tb_star_cif_byte_tokenizer_core: FAIL");
        end
        $finish;
    end

endmodule
